/* sv/adfgvx_encryptor_assert.svh */
// ----------------------------------------------------------------------------
// ADFGVX encryptor assertion macros
// Concurrent assertion wrappers on clk; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef ADFGVX_ENCRYPTOR_ASSERT_SVH
`define ADFGVX_ENCRYPTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define AE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AE_ASSERT_CLK(lbl, prop, msg)
`define AE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* sv/adfgvx_pkg.sv */
// ----------------------------------------------------------------------------
// ADFGVX package
// Request types, register indexes, error codes and the digit letter table.
// ----------------------------------------------------------------------------
package adfgvx_pkg;

  localparam int MAX_MESSAGE_DEF = 32;
  localparam int MAX_KEY_DEF     = 8;
  localparam int SQUARE_DIM      = 6;
  localparam int SQUARE_CELLS    = SQUARE_DIM * SQUARE_DIM;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LETTERS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH  = 3'd6;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;

  localparam logic [6:0] LETTER_A = 7'h41;
  localparam logic [6:0] LETTER_D = 7'h44;
  localparam logic [6:0] LETTER_F = 7'h46;
  localparam logic [6:0] LETTER_G = 7'h47;
  localparam logic [6:0] LETTER_V = 7'h56;
  localparam logic [6:0] LETTER_X = 7'h58;
  localparam logic [6:0] LETTER_NONE = 7'h00;

  typedef struct packed {
    logic [7:0] plain_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cipher_letter;
    logic [1:0] error_code;
    logic       last_out;
  } out_item_t;

  // digit values wrap modulo the square size
  function automatic logic [6:0] digit_letter(input logic [2:0] digit);
    logic [6:0] letter;
    unique case (digit)
      3'd0:    letter = LETTER_A;
      3'd1:    letter = LETTER_D;
      3'd2:    letter = LETTER_F;
      3'd3:    letter = LETTER_G;
      3'd4:    letter = LETTER_V;
      3'd5:    letter = LETTER_X;
      3'd6:    letter = LETTER_A;
      default: letter = LETTER_D;
    endcase
    return letter;
  endfunction

endpackage

/* sv/adfgvx_encryptor.sv */
// Bytes that are not marked last are taken one per cycle, back to back.
// After the last byte the block passes through a start state, then the transposed letters
// leave one at a time: one digit memory read in flight, then the output register, and an
// output stall holds the readout (2N letters for N bytes). Input is stalled during the readout.
// Synchronous reset clears control state and the configuration registers (key length
// to one); the digit memory is not cleared.
// ----------------------------------------------------------------------------
// ADFGVX encryptor
// Square substitution into a digit memory, columnar transposition on readout.
// ----------------------------------------------------------------------------
module adfgvx_encryptor #(
  parameter int MAX_MESSAGE = adfgvx_pkg::MAX_MESSAGE_DEF,
  parameter int MAX_KEY     = adfgvx_pkg::MAX_KEY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [adfgvx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [adfgvx_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  adfgvx_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output adfgvx_pkg::out_item_t               out_data
);

`include "adfgvx_encryptor_assert.svh"

  localparam int CNT_W  = $clog2(MAX_MESSAGE + 1);
  localparam int TOT_W  = CNT_W + 1;
  localparam int ADDR_W = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
  localparam int POS_W  = $clog2(2 * MAX_MESSAGE + MAX_KEY + 1);
  localparam int KEY_W  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int LEN_W  = $clog2(MAX_KEY + 1);
  localparam int DIM    = adfgvx_pkg::SQUARE_DIM;

  typedef enum logic [1:0] {S_IDLE, S_START, S_EMIT} state_t;

  // configuration
  logic [7:0]  square [adfgvx_pkg::SQUARE_CELLS];
  logic [63:0] key_letters;
  logic [3:0]  key_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      square      <= '{default: '0};
      key_letters <= '0;
      key_length  <= 4'd1;
    end else if (cfg_write) begin
      for (int w = 0; w < 5; w++) begin
        for (int b = 0; b < 8; b++) begin
          if (w * 8 + b < adfgvx_pkg::SQUARE_CELLS &&
              cfg_index == adfgvx_pkg::REG_SQUARE_0 + 3'(w)) begin
            square[w * 8 + b] <= cfg_data[8 * b +: 8];
          end
        end
      end
      if (cfg_index == adfgvx_pkg::REG_KEY_LETTERS) begin
        key_letters <= cfg_data;
      end
      if (cfg_index == adfgvx_pkg::REG_KEY_LENGTH) begin
        key_length <= cfg_data[3:0];
      end
    end
  end

  // key ordering
  logic [LEN_W-1:0] len_eff;
  logic [KEY_W-1:0] rank [MAX_KEY];
  logic [KEY_W-1:0] order [2**KEY_W];
  logic [KEY_W-1:0] order_q [2**KEY_W];

  always_comb begin
    if (key_length == 4'd0) begin
      len_eff = LEN_W'(1);
    end else if (key_length > 4'(MAX_KEY)) begin
      len_eff = LEN_W'(MAX_KEY);
    end else begin
      len_eff = key_length[LEN_W-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_KEY; c++) begin
      rank[c] = '0;
      for (int d = 0; d < MAX_KEY; d++) begin
        if (LEN_W'(d) < len_eff &&
            (key_letters[8 * d +: 8] < key_letters[8 * c +: 8] ||
             (key_letters[8 * d +: 8] == key_letters[8 * c +: 8] && d < c))) begin
          rank[c] = rank[c] + KEY_W'(1);
        end
      end
    end
    order = '{default: '0};
    for (int c = 0; c < MAX_KEY; c++) begin
      if (LEN_W'(c) < len_eff) begin
        order[rank[c]] = KEY_W'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    order_q <= order;
  end

  // square lookup, first match in row-major order
  logic       found;
  logic [2:0] hit_row;
  logic [2:0] hit_col;

  always_comb begin
    found   = 1'b0;
    hit_row = '0;
    hit_col = '0;
    for (int r = DIM - 1; r >= 0; r--) begin
      for (int c = DIM - 1; c >= 0; c--) begin
        if (square[r * DIM + c] == in_data.plain_char) begin
          found   = 1'b1;
          hit_row = 3'(r);
          hit_col = 3'(c);
        end
      end
    end
  end

  // control state
  state_t           state;
  logic [CNT_W-1:0] char_count;
  logic [1:0]       error_seen;
  logic [1:0]       final_err;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] emit_left;
  logic [POS_W-1:0] pos;
  logic [KEY_W-1:0] col_rank;
  logic             rd_vld;
  logic             rd_half;
  logic             rd_last;
  logic [5:0]       rd_entry;

  logic             in_take;
  logic             out_take;
  logic             wr_en;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       error_next;
  logic             pos_in;
  logic             issue;
  logic             err_load;
  logic [2:0]       rd_digit;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign pos_in   = (pos < POS_W'(total));
  assign issue    = (state == S_EMIT) && pos_in && !rd_vld && (!out_valid || out_take);
  assign err_load = (state == S_START) && (final_err != adfgvx_pkg::ERR_NONE) &&
                    (!out_valid || out_take);
  assign rd_digit = rd_half ? rd_entry[2:0] : rd_entry[5:3];

  always_comb begin
    wr_en      = 1'b0;
    count_next = char_count;
    error_next = error_seen;
    if (!found) begin
      if (error_seen == adfgvx_pkg::ERR_NONE) begin
        error_next = adfgvx_pkg::ERR_CHAR;
      end
    end else if (char_count >= CNT_W'(MAX_MESSAGE)) begin
      if (error_seen == adfgvx_pkg::ERR_NONE) begin
        error_next = adfgvx_pkg::ERR_LENGTH;
      end
    end else if (error_seen == adfgvx_pkg::ERR_NONE) begin
      wr_en      = in_take;
      count_next = char_count + CNT_W'(1);
    end
  end

  // digit memory: one entry per byte, row digit high, column digit low
  logic [5:0] digit_mem [MAX_MESSAGE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[char_count[ADDR_W-1:0]] <= {hit_row, hit_col};
    end
    if (issue) begin
      rd_entry <= digit_mem[pos[ADDR_W:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_count <= '0;
      error_seen <= adfgvx_pkg::ERR_NONE;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= issue;
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (in_data.last_char) begin
              final_err  <= error_next;
              total      <= {count_next, 1'b0};
              char_count <= '0;
              error_seen <= adfgvx_pkg::ERR_NONE;
              state      <= S_START;
            end else begin
              char_count <= count_next;
              error_seen <= error_next;
            end
          end
        end
        S_START: begin
          if (final_err != adfgvx_pkg::ERR_NONE) begin
            if (err_load) begin
              state <= S_IDLE;
            end
          end else if (total == '0) begin
            state <= S_IDLE;
          end else begin
            col_rank  <= '0;
            pos       <= POS_W'(order_q[0]);
            emit_left <= total;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!pos_in) begin
            col_rank <= col_rank + KEY_W'(1);
            pos      <= POS_W'(order_q[col_rank + KEY_W'(1)]);
          end else if (issue) begin
            pos       <= pos + POS_W'(len_eff);
            emit_left <= emit_left - TOT_W'(1);
            rd_half   <= pos[0];
            rd_last   <= (emit_left == TOT_W'(1));
            if (emit_left == TOT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      priority if (rd_vld) begin
        out_valid              <= 1'b1;
        out_data.cipher_letter <= adfgvx_pkg::digit_letter(rd_digit);
        out_data.error_code    <= adfgvx_pkg::ERR_NONE;
        out_data.last_out      <= rd_last;
      end else if (err_load) begin
        out_valid              <= 1'b1;
        out_data.cipher_letter <= adfgvx_pkg::LETTER_NONE;
        out_data.error_code    <= final_err;
        out_data.last_out      <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  `AE_ASSERT_CLK(a_read_lands, rd_vld |=> (out_valid && out_data.error_code == adfgvx_pkg::ERR_NONE), "digit read did not reach output")
  `AE_ASSERT_CLK(a_one_read, rd_vld |-> !issue, "second digit read while one in flight")
  `AE_ASSERT_CLK(a_emit_left, (state == S_EMIT) |-> (emit_left != '0), "readout with no letters left")
  `AE_ASSERT_CLK(a_error_last, (out_valid && out_data.error_code != adfgvx_pkg::ERR_NONE) |-> out_data.last_out, "error result not marked last")
  `AE_ASSERT_RST(a_reset_idle, rst |=> (state == S_IDLE && !out_valid && !rd_vld), "control not cleared by reset")

endmodule
